[rtl/rar_pkg.sv]
// shared types and constants for the rational arithmetic reduce block
`timescale 1ns / 1ps
package rar_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned MAG_W  = 64;
    localparam int unsigned OUT_W  = 63;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [DATA_W-1:0] a_num;
        logic signed [DATA_W-1:0] a_den;
        logic signed [DATA_W-1:0] b_num;
        logic signed [DATA_W-1:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic             status;
        logic             negative;
        logic [OUT_W-1:0] whole_part;
        logic [OUT_W-1:0] frac_num;
        logic [OUT_W-1:0] frac_den;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SIGN,
        ST_GCD_START,
        ST_GCD_RUN,
        ST_RED_START,
        ST_RED_RUN,
        ST_WHOLE_START,
        ST_WHOLE_RUN,
        ST_DONE
    } state_t;

    // datapath commands
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sign;
        logic gcd_start;
        logic gcd_step;
        logic red_start;
        logic red_step;
        logic whole_start;
        logic whole_step;
    } dp_cmd_t;

    // datapath status
    typedef struct packed {
        logic den_zero;
        logic num_zero;
        logic gcd_done;
        logic div_done;
    } dp_sts_t;

endpackage

[rtl/rational_alu_reduce_core.sv]
// top level of the rational arithmetic reduce block
`timescale 1ns / 1ps
// Takes one transfer of two fractions and an operation, forms exact 64-bit
// cross products, reduces by the gcd of the magnitudes and returns a mixed
// number. One item at a time on one shared bit-serial restoring divider:
// after the input transfer come the two products and the sign step, then
// the Euclid iterations of the gcd, the two reduce divisions and the
// whole/remainder split; an undefined or zero result skips the divider steps.
// The result is held on m_ until taken, and the next item is accepted in the
// cycle after the result transfer.
module rational_alu_reduce_core #(
    parameter int unsigned MagW = rar_pkg::MAG_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rar_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rar_pkg::out_item_t m_data
);
    rar_pkg::dp_cmd_t cmd;
    rar_pkg::dp_sts_t sts;

    rar_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rar_datapath #(.MagW(MagW)) u_dp (
        .aclk    (aclk),
        .in_item (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .result  (m_data)
    );

    // no new input while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input accepted while result pending");
    // result held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    // undefined result has unit denominator
    a_undef: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> m_data.frac_den == rar_pkg::OUT_W'(1) && !m_data.negative)
        else $error("bad undefined result");
endmodule

[rtl/rar_datapath.sv]
// datapath: cross products, sign handling, gcd, reduce and mixed number split
`timescale 1ns / 1ps
module rar_datapath #(
    parameter int unsigned MagW = rar_pkg::MAG_W
) (
    input  logic                aclk,
    input  rar_pkg::in_item_t   in_item,
    input  rar_pkg::dp_cmd_t    cmd,
    output rar_pkg::dp_sts_t    sts,
    output rar_pkg::out_item_t  result
);
    localparam int unsigned CntW = $clog2(MagW + 1);

    rar_pkg::in_item_t item_reg, item_next;
    logic [MagW-1:0] p1_reg, p1_next, p2_reg, p2_next, den_reg, den_next;
    logic [MagW-1:0] nmag_reg, nmag_next, dmag_reg, dmag_next;
    logic            neg_reg, neg_next;
    // gcd via euclid, remainder by restoring division
    logic [MagW-1:0] x_reg, x_next, y_reg, y_next;
    // shared divider: quo/rem of dvd by dvs
    logic [MagW-1:0] dvd_reg, dvd_next, dvs_reg, dvs_next;
    logic [MagW-1:0] quo_reg, quo_next, rem_reg, rem_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            gcd_mode_reg, gcd_mode_next;
    logic [MagW-1:0] g_reg, g_next;

    logic signed [2*rar_pkg::DATA_W-1:0] prod_a, prod_b;
    logic signed [rar_pkg::DATA_W-1:0]   ma0, ma1, mb0, mb1;
    logic [MagW-1:0] num_raw;
    logic [MagW:0]   trial;
    logic [MagW-1:0] rem_shift;
    logic [MagW-1:0] dmask;

    // operand selection for the two multipliers
    always_comb begin
        ma0 = item_reg.a_num;
        mb0 = item_reg.b_den;
        ma1 = item_reg.a_den;
        mb1 = item_reg.b_num;
        if (cmd.mul2) begin
            ma0 = item_reg.a_den;
            mb0 = (item_reg.operation == rar_pkg::OP_DIV) ? item_reg.b_num : item_reg.b_den;
            ma1 = item_reg.a_num;
            mb1 = item_reg.b_num;
        end
    end

    assign prod_a = ma0 * mb0;
    assign prod_b = ma1 * mb1;

    // one restoring division step
    assign rem_shift = {rem_reg[MagW-2:0], dvd_reg[MagW-1]};
    assign trial     = {1'b0, rem_shift} - {1'b0, dvs_reg};

    always_comb begin
        unique case (item_reg.operation)
            rar_pkg::OP_ADD: num_raw = p1_reg + p2_reg;
            rar_pkg::OP_SUB: num_raw = p1_reg - p2_reg;
            rar_pkg::OP_MUL: num_raw = p2_reg;
            default:         num_raw = p1_reg;
        endcase
    end

    always_comb begin
        item_next     = item_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        den_next      = den_reg;
        nmag_next     = nmag_reg;
        dmag_next     = dmag_reg;
        neg_next      = neg_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        dvd_next      = dvd_reg;
        dvs_next      = dvs_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        gcd_mode_next = gcd_mode_reg;
        g_next        = g_reg;

        if (cmd.load) begin
            item_next = in_item;
        end
        // first products: a_num*b_den and a_den*b_num
        if (cmd.mul1) begin
            p1_next = MagW'(prod_a);
            p2_next = MagW'(prod_b);
        end
        // denominator product; multiply takes a_num*b_num in place of p2
        if (cmd.mul2) begin
            den_next = MagW'(prod_a);
            if (item_reg.operation == rar_pkg::OP_MUL) begin
                p2_next = MagW'(prod_b);
            end
        end
        // move sign to the numerator
        if (cmd.sign) begin
            nmag_next = num_raw[MagW-1] ? (MagW'(0) - num_raw) : num_raw;
            dmag_next = den_reg[MagW-1] ? (MagW'(0) - den_reg) : den_reg;
            neg_next  = num_raw[MagW-1] ^ den_reg[MagW-1];
        end
        if (cmd.gcd_start) begin
            x_next        = nmag_reg;
            y_next        = dmag_reg;
            dvd_next      = nmag_reg;
            dvs_next      = dmag_reg;
            rem_next      = '0;
            quo_next      = '0;
            cnt_next      = '0;
            gcd_mode_next = 1'b1;
        end
        if (cmd.red_start) begin
            g_next        = x_reg;
            dvd_next      = nmag_reg;
            dvs_next      = x_reg;
            rem_next      = '0;
            quo_next      = '0;
            cnt_next      = '0;
            gcd_mode_next = 1'b0;
        end
        if (cmd.whole_start) begin
            nmag_next     = quo_reg;
            dvd_next      = quo_reg;
            dvs_next      = dmag_reg;
            rem_next      = '0;
            quo_next      = '0;
            cnt_next      = '0;
        end
        // divider steps for gcd, reduce and whole split; dmag is reduced by gcd in a second pass reusing the divider
        if (cmd.gcd_step || cmd.red_step || cmd.whole_step) begin
            if (cnt_reg == CntW'(MagW)) begin
                if (cmd.gcd_step) begin
                    // euclid iteration done; next pair
                    x_next   = y_reg;
                    y_next   = rem_reg;
                    dvd_next = y_reg;
                    dvs_next = rem_reg;
                    rem_next = '0;
                    quo_next = '0;
                    cnt_next = '0;
                end else if (cmd.red_step && gcd_mode_reg == 1'b0) begin
                    // numerator done; now denominator
                    nmag_next     = quo_reg;
                    dvd_next      = dmag_reg;
                    dvs_next      = g_reg;
                    rem_next      = '0;
                    quo_next      = '0;
                    cnt_next      = '0;
                    gcd_mode_next = 1'b1;
                end else if (cmd.red_step) begin
                    dmag_next = quo_reg;
                    quo_next  = nmag_reg;
                end
            end else begin
                dvd_next = {dvd_reg[MagW-2:0], 1'b0};
                cnt_next = cnt_reg + CntW'(1);
                if (!trial[MagW]) begin
                    rem_next = trial[MagW-1:0];
                    quo_next = {quo_reg[MagW-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift;
                    quo_next = {quo_reg[MagW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        den_reg      <= den_next;
        nmag_reg     <= nmag_next;
        dmag_reg     <= dmag_next;
        neg_reg      <= neg_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        dvd_reg      <= dvd_next;
        dvs_reg      <= dvs_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        gcd_mode_reg <= gcd_mode_next;
        g_reg        <= g_next;
    end

    // status back to the controller; the first reduce pass runs with gcd_mode low
    assign sts.den_zero = (den_reg == '0);
    assign sts.num_zero = (nmag_reg == '0);
    assign sts.gcd_done = (y_reg == '0);
    assign sts.div_done = (cnt_reg == CntW'(MagW)) && gcd_mode_reg;

    // result formatting
    assign dmask = {1'b0, {(MagW-1){1'b1}}};
    always_comb begin
        result            = '0;
        result.frac_den   = rar_pkg::OUT_W'(1);
        if (sts.den_zero) begin
            result.status = 1'b1;
        end else if (!sts.num_zero) begin
            result.negative   = neg_reg;
            result.whole_part = rar_pkg::OUT_W'(quo_reg & dmask);
            if (rem_reg != '0) begin
                result.frac_num = rar_pkg::OUT_W'(rem_reg & dmask);
                result.frac_den = rar_pkg::OUT_W'(dmag_reg & dmask);
            end
        end
    end
endmodule

[rtl/rar_ctrl.sv]
// controller state machine: sequences the datapath and runs the handshakes
`timescale 1ns / 1ps
module rar_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  rar_pkg::dp_sts_t sts,
    output rar_pkg::dp_cmd_t cmd
);
    rar_pkg::state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rar_pkg::ST_IDLE:        if (s_valid) state_next = rar_pkg::ST_MUL1;
            rar_pkg::ST_MUL1:        state_next = rar_pkg::ST_MUL2;
            rar_pkg::ST_MUL2:        state_next = rar_pkg::ST_SIGN;
            rar_pkg::ST_SIGN:        state_next = rar_pkg::ST_GCD_START;
            rar_pkg::ST_GCD_START: begin
                if (sts.den_zero || sts.num_zero) state_next = rar_pkg::ST_DONE;
                else                              state_next = rar_pkg::ST_GCD_RUN;
            end
            rar_pkg::ST_GCD_RUN:     if (sts.gcd_done) state_next = rar_pkg::ST_RED_START;
            rar_pkg::ST_RED_START:   state_next = rar_pkg::ST_RED_RUN;
            rar_pkg::ST_RED_RUN:     if (sts.div_done) state_next = rar_pkg::ST_WHOLE_START;
            rar_pkg::ST_WHOLE_START: state_next = rar_pkg::ST_WHOLE_RUN;
            rar_pkg::ST_WHOLE_RUN:   if (sts.div_done) state_next = rar_pkg::ST_DONE;
            rar_pkg::ST_DONE:        if (m_ready) state_next = rar_pkg::ST_IDLE;
            default:                 state_next = rar_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd         = '0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        unique case (state_reg)
            rar_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            rar_pkg::ST_MUL1:        cmd.mul1 = 1'b1;
            rar_pkg::ST_MUL2:        cmd.mul2 = 1'b1;
            rar_pkg::ST_SIGN:        cmd.sign = 1'b1;
            rar_pkg::ST_GCD_START:   cmd.gcd_start = !(sts.den_zero || sts.num_zero);
            rar_pkg::ST_GCD_RUN:     cmd.gcd_step = !sts.gcd_done;
            rar_pkg::ST_RED_START:   cmd.red_start = 1'b1;
            rar_pkg::ST_RED_RUN:     cmd.red_step = 1'b1;
            rar_pkg::ST_WHOLE_START: cmd.whole_start = 1'b1;
            rar_pkg::ST_WHOLE_RUN:   cmd.whole_step = !sts.div_done;
            rar_pkg::ST_DONE:        m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rar_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
